/* design/dtq_pkg.sv */
// Shared types and constants for the deadline task queue.
`default_nettype none

package dtq_pkg;

  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 2;
  localparam int QCNT_W  = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

  // One queue slot as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] start_time;
  } slot_t;

  // Outputs of the shared add/compare unit
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              eq;
    logic              lt;
  } alu_res_t;

  // One result item
  typedef struct packed {
    logic              ok;
    logic              front_valid;
    logic [ID_W-1:0]   front_task_id;
    logic [TIME_W-1:0] front_start_time;
    logic [QCNT_W-1:0] queue_count;
    logic [TIME_W-1:0] time_now_out;
  } res_t;

endpackage

`default_nettype wire

/* design/dtq_if.sv */
// Command and result channel interfaces of the deadline task queue.
`default_nettype none

interface dtq_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [dtq_pkg::CMD_W-1:0]  command;
  logic [dtq_pkg::ID_W-1:0]   task_id;
  logic [dtq_pkg::TIME_W-1:0] start_offset;

  modport source (output valid, command, task_id, start_offset, input ready);
  modport sink   (input valid, command, task_id, start_offset, output ready);
endinterface

interface dtq_res_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic                       front_valid;
  logic [dtq_pkg::ID_W-1:0]   front_task_id;
  logic [dtq_pkg::TIME_W-1:0] front_start_time;
  logic [dtq_pkg::QCNT_W-1:0] queue_count;
  logic [dtq_pkg::TIME_W-1:0] time_now_out;

  modport source (output valid, ok, front_valid, front_task_id, front_start_time,
                  queue_count, time_now_out, input ready);
  modport sink   (input valid, ok, front_valid, front_task_id, front_start_time,
                  queue_count, time_now_out, output ready);
endinterface

`default_nettype wire

/* design/deadline_task_queue_unit.sv */
// Each command steps through the slots one at a time: modify and remove search from the oldest
//   entry for the id, remove then moves each later entry down, and every command ends with a scan.
// The scan reads all queued entries to find the front, so a miss on a full queue reads every slot.
//   One command in flight; the next is taken the cycle after the result is loaded. The slot-by-slot
//   pace is set by the single read port of the slot memory feeding the shared add/compare unit.
// Reset clears count, time and result valid; slot memory is left as is (no clearing pass).
`default_nettype none

module deadline_task_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dtq_cmd_if.sink     cmd_i,
  dtq_res_if.source   res_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = CW + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_FIND_RD  = 4'd2;
  localparam logic [3:0] S_FIND_CK  = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CK  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]                  state_q, state_d;
  logic [dtq_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [dtq_pkg::ID_W-1:0]    id_q, id_d;
  logic [dtq_pkg::TIME_W-1:0]  ofs_q, ofs_d;
  logic [dtq_pkg::TIME_W-1:0]  new_start_q, new_start_d;
  logic [dtq_pkg::TIME_W-1:0]  time_q, time_d;
  logic [IW-1:0]               ptr_q, ptr_d;
  logic [CW-1:0]               count_q, count_d;
  logic                        ok_q, ok_d;
  logic                        best_valid_q, best_valid_d;
  dtq_pkg::slot_t              best_q, best_d;
  logic                        res_valid_q, res_valid_d;
  dtq_pkg::res_t               res_q, res_d;

  logic                        we;
  logic [IW-1:0]               waddr, raddr;
  dtq_pkg::slot_t              wdata, rdata;
  logic [dtq_pkg::TIME_W-1:0]  alu_a, alu_b;
  dtq_pkg::alu_res_t           alu;
  logic [XW-1:0]               ptr_x, count_x;
  logic                        start_scan;

  dtq_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dtq_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  assign ptr_x   = XW'(ptr_q);
  assign count_x = XW'(count_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    ofs_d        = ofs_q;
    new_start_d  = new_start_q;
    time_d       = time_q;
    ptr_d        = ptr_q;
    count_d      = count_q;
    ok_d         = ok_q;
    best_valid_d = best_valid_q;
    best_d       = best_q;
    res_valid_d  = res_valid_q;
    res_d        = res_q;
    we           = 1'b0;
    waddr        = ptr_q;
    wdata        = rdata;
    raddr        = ptr_q;
    alu_a        = '0;
    alu_b        = '0;
    start_scan   = 1'b0;

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.command;
          id_d    = cmd_i.task_id;
          ofs_d   = cmd_i.start_offset;
          state_d = S_EXEC;
        end
      end

      // New start time (or time + 1 on tick) through the shared unit
      S_EXEC: begin
        alu_a = time_q;
        alu_b = (cmd_q == dtq_pkg::CMD_TICK) ? dtq_pkg::TIME_W'(1) : ofs_q;
        ok_d  = 1'b0;
        ptr_d = '0;
        case (cmd_q)
          dtq_pkg::CMD_ADD: begin
            if (count_x < XW'(QUEUE_DEPTH)) begin
              we      = 1'b1;
              waddr   = count_q[IW-1:0];
              wdata   = '{task_id: id_q, start_time: alu.sum};
              count_d = count_q + CW'(1);
              ok_d    = 1'b1;
            end
            start_scan = 1'b1;
          end
          dtq_pkg::CMD_MODIFY, dtq_pkg::CMD_REMOVE: begin
            new_start_d = alu.sum;
            if (count_q == '0) begin
              start_scan = 1'b1;
            end else begin
              state_d = S_FIND_RD;
            end
          end
          default: begin
            time_d     = alu.sum;
            ok_d       = 1'b1;
            start_scan = 1'b1;
          end
        endcase
      end

      S_FIND_RD: begin
        state_d = S_FIND_CK;
      end

      // Id match on the slot just read; first match wins
      S_FIND_CK: begin
        alu_a = rdata.task_id;
        alu_b = id_q;
        if (alu.eq) begin
          ok_d = 1'b1;
          if (cmd_q == dtq_pkg::CMD_MODIFY) begin
            we         = 1'b1;
            wdata      = '{task_id: rdata.task_id, start_time: new_start_q};
            start_scan = 1'b1;
          end else if (ptr_x + XW'(1) < count_x) begin
            state_d = S_SHIFT_RD;
          end else begin
            count_d    = count_q - CW'(1);
            start_scan = 1'b1;
          end
        end else if (ptr_x + XW'(1) >= count_x) begin
          start_scan = 1'b1;
        end else begin
          ptr_d   = ptr_q + IW'(1);
          state_d = S_FIND_RD;
        end
      end

      // Remove: move later entries down one slot to keep addition order
      S_SHIFT_RD: begin
        raddr   = ptr_q + IW'(1);
        state_d = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        we    = 1'b1;
        ptr_d = ptr_q + IW'(1);
        if (ptr_x + XW'(2) < count_x) begin
          state_d = S_SHIFT_RD;
        end else begin
          count_d    = count_q - CW'(1);
          start_scan = 1'b1;
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_CK;
      end

      // Running minimum; strict less keeps the oldest on ties
      S_SCAN_CK: begin
        alu_a = rdata.start_time;
        alu_b = best_q.start_time;
        if (!best_valid_q || alu.lt) begin
          best_d = rdata;
        end
        best_valid_d = 1'b1;
        if (ptr_x + XW'(1) >= count_x) begin
          state_d = S_DONE;
        end else begin
          ptr_d   = ptr_q + IW'(1);
          state_d = S_SCAN_RD;
        end
      end

      // Load the result register once it is free
      S_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d            = 1'b1;
          res_d.ok               = ok_q;
          res_d.front_valid      = best_valid_q;
          res_d.front_task_id    = best_valid_q ? best_q.task_id : '0;
          res_d.front_start_time = best_valid_q ? best_q.start_time : '0;
          res_d.queue_count      = dtq_pkg::QCNT_W'(count_q);
          res_d.time_now_out     = time_q;
          state_d                = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (start_scan) begin
      ptr_d        = '0;
      best_valid_d = 1'b0;
      state_d      = (count_d == '0) ? S_DONE : S_SCAN_RD;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      time_q       <= '0;
      ptr_q        <= '0;
      best_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      time_q       <= time_d;
      ptr_q        <= ptr_d;
      best_valid_q <= best_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    id_q        <= id_d;
    ofs_q       <= ofs_d;
    new_start_q <= new_start_d;
    ok_q        <= ok_d;
    best_q      <= best_d;
    res_q       <= res_d;
  end

  assign cmd_i.ready            = (state_q == S_IDLE);
  assign res_o.valid            = res_valid_q;
  assign res_o.ok               = res_q.ok;
  assign res_o.front_valid      = res_q.front_valid;
  assign res_o.front_task_id    = res_q.front_task_id;
  assign res_o.front_start_time = res_q.front_start_time;
  assign res_o.queue_count      = res_q.queue_count;
  assign res_o.time_now_out     = res_q.time_now_out;

endmodule

`default_nettype wire

/* design/dtq_slot_ram.sv */
// Slot memory: one write port, one read port with registered read data.
`default_nettype none

module dtq_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire dtq_pkg::slot_t wdata_i,
  input  wire logic [AW-1:0]  raddr_i,
  output dtq_pkg::slot_t      rdata_o
);

  dtq_pkg::slot_t mem_q [DEPTH];
  dtq_pkg::slot_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data valid in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/dtq_alu.sv */
// Shared 32-bit add and compare unit used by the exec, id-match and scan steps of the sequencer.
`default_nettype none

module dtq_alu (
  input  wire logic [dtq_pkg::TIME_W-1:0] a_i,
  input  wire logic [dtq_pkg::TIME_W-1:0] b_i,
  output dtq_pkg::alu_res_t               res_o
);

  // Sum wraps modulo 2^32; compares are unsigned
  always_comb begin
    res_o.sum = a_i + b_i;
    res_o.eq  = (a_i == b_i);
    res_o.lt  = (a_i < b_i);
  end

endmodule

`default_nettype wire

/* design/dtq_checker.sv */
// Port-level checks for the deadline task queue, bound to the top level.
`default_nettype none

module dtq_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       cmd_valid_i,
  input wire logic                       cmd_ready_i,
  input wire logic                       res_valid_i,
  input wire logic                       res_ready_i,
  input wire logic                       res_front_valid_i,
  input wire logic [dtq_pkg::ID_W-1:0]   res_front_task_id_i,
  input wire logic [dtq_pkg::TIME_W-1:0] res_front_start_time_i,
  input wire logic [dtq_pkg::QCNT_W-1:0] res_queue_count_i,
  input wire logic [dtq_pkg::TIME_W-1:0] res_time_now_out_i
);

  // Only one command in flight: ready drops right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> !cmd_ready_i)
    else $error("command accepted while previous one in flight");

  // An empty front reads as all zero with a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_front_valid_i) |->
      (res_front_task_id_i == '0 && res_front_start_time_i == '0 &&
       res_queue_count_i == '0))
    else $error("empty queue result carries nonzero front or count");

  // A nonzero count always comes with a valid front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_queue_count_i != '0) |-> res_front_valid_i)
    else $error("queued tasks but no front entry");

  // Result held until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_time_now_out_i)))
    else $error("result dropped or changed while stalled");

endmodule

bind deadline_task_queue_unit dtq_checker u_dtq_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .cmd_valid_i            (cmd_i.valid),
  .cmd_ready_i            (cmd_i.ready),
  .res_valid_i            (res_o.valid),
  .res_ready_i            (res_o.ready),
  .res_front_valid_i      (res_o.front_valid),
  .res_front_task_id_i    (res_o.front_task_id),
  .res_front_start_time_i (res_o.front_start_time),
  .res_queue_count_i      (res_o.queue_count),
  .res_time_now_out_i     (res_o.time_now_out)
);

`default_nettype wire

/* sim/dtq_checker.sv */
// Checker for the deadline task queue: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module dtq_tb_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  dtq_cmd_if   cmd_i,
  dtq_res_if   res_i,
  output int   err_cnt_o,
  output int   pending_o
);
  import dtq_pkg::*;

  // Shadow queue, kept packed in order of addition
  logic [ID_W-1:0]   sched_id    [QUEUE_DEPTH];
  logic [TIME_W-1:0] sched_start [QUEUE_DEPTH];
  int                sched_len;
  logic [TIME_W-1:0] clock_secs;

  res_t results_due[$];
  int   fail_cnt = 0;

  assign err_cnt_o = fail_cnt;

  // Apply one command to the shadow queue and return the status it reports
  function automatic res_t schedule_step(input logic [CMD_W-1:0]  op,
                                         input logic [ID_W-1:0]   id,
                                         input logic [TIME_W-1:0] ofs);
    res_t r;
    int   hit;
    int   best;
    r    = '0;
    hit  = -1;
    best = -1;
    // modify and remove act on the earliest-added match only
    for (int i = 0; i < sched_len; i++) begin
      if (hit < 0 && sched_id[i] == id) hit = i;
    end
    case (op)
      CMD_ADD: begin
        if (sched_len < QUEUE_DEPTH) begin
          sched_id[sched_len]    = id;
          sched_start[sched_len] = clock_secs + ofs;
          sched_len++;
          r.ok = 1'b1;
        end
      end
      CMD_MODIFY: begin
        if (hit >= 0) begin
          sched_start[hit] = clock_secs + ofs;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < sched_len; i++) begin
            sched_id[i]    = sched_id[i+1];
            sched_start[i] = sched_start[i+1];
          end
          sched_len--;
          r.ok = 1'b1;
        end
      end
      default: begin
        clock_secs = clock_secs + 1'b1;
        r.ok = 1'b1;
      end
    endcase
    // earliest start wins; ties go to the older entry (strict compare)
    for (int i = 0; i < sched_len; i++) begin
      if (best < 0 || sched_start[i] < sched_start[best]) best = i;
    end
    if (best >= 0) begin
      r.front_valid      = 1'b1;
      r.front_task_id    = sched_id[best];
      r.front_start_time = sched_start[best];
    end
    r.queue_count  = QCNT_W'(sched_len);
    r.time_now_out = clock_secs;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  // Watch both channels; results are matched in order against predictions
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      sched_len  = 0;
      clock_secs = '0;
      results_due.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_cnt++;
        end else begin
          want = results_due.pop_front();
          check_field("ok", 32'(want.ok), 32'(res_i.ok));
          check_field("front_valid", 32'(want.front_valid), 32'(res_i.front_valid));
          check_field("front_task_id", want.front_task_id, res_i.front_task_id);
          check_field("front_start_time", want.front_start_time, res_i.front_start_time);
          check_field("queue_count", 32'(want.queue_count), 32'(res_i.queue_count));
          check_field("time_now_out", want.time_now_out, res_i.time_now_out);
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        results_due = {results_due, schedule_step(cmd_i.command, cmd_i.task_id,
                                                  cmd_i.start_offset)};
      end
    end
    pending_o <= results_due.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for the deadline task queue: reset, clock, command stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import dtq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_ITEMS   = 150;   // closing stretch with no idling
  localparam int HOLD_AT_ITEM = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 120;   // above worst-case command latency

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending_cnt;
  bit   tx_idle_on  = 1'b0;
  bit   rx_idle_on  = 1'b0;
  bit   rx_hold_req = 1'b0;

  // recently added ids, so modify and remove mostly hit
  logic [ID_W-1:0] id_pool[$];

  dtq_cmd_if cmd_if ();
  dtq_res_if res_if ();

  deadline_task_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  dtq_tb_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_if),
    .res_i    (res_if),
    .err_cnt_o(fail_cnt),
    .pending_o(pending_cnt)
  );

  always #4 clk_i = ~clk_i;

  // Offer one command and hold it until the transfer, then maybe go quiet
  task automatic send_cmd(input logic [CMD_W-1:0]  op,
                          input logic [ID_W-1:0]   id,
                          input logic [TIME_W-1:0] ofs);
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= op;
    cmd_if.task_id      <= id;
    cmd_if.start_offset <= ofs;
    do @(posedge clk_i); while (!cmd_if.ready);
    if (op == CMD_ADD) begin
      id_pool = {id_pool, id};
      if (id_pool.size() > 24) void'(id_pool.pop_front());
    end
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Result side: ready with random stall bursts and one long hold-off
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin
    int                r;
    int                phase;
    logic [CMD_W-1:0]  op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ofs;

    cmd_if.valid        <= 1'b0;
    cmd_if.command      <= CMD_ADD;
    cmd_if.task_id      <= '0;
    cmd_if.start_offset <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, wrap of start time, ties, duplicates, misses, full queue
    send_cmd(CMD_REMOVE, '0, '0);
    send_cmd(CMD_MODIFY, '1, '1);
    send_cmd(CMD_TICK, '1, '1);            // id and offset ignored
    send_cmd(CMD_ADD, '1, '1);             // start wraps to zero
    send_cmd(CMD_ADD, '0, '0);
    send_cmd(CMD_ADD, 32'd5, 32'd10);
    send_cmd(CMD_ADD, 32'd5, 32'd10);      // duplicate id, equal start
    send_cmd(CMD_ADD, 32'd6, 32'd10);
    send_cmd(CMD_MODIFY, '1, 32'd12);      // front moves away from the wrapped entry
    send_cmd(CMD_MODIFY, 32'd5, '0);       // ties with id 0, older entry keeps front
    send_cmd(CMD_REMOVE, '0, '0);
    send_cmd(CMD_REMOVE, 32'd5, '0);       // earlier of the two duplicates
    send_cmd(CMD_MODIFY, 32'h1234_5678, '0);
    send_cmd(CMD_REMOVE, 32'h1234_5678, '0);
    // fill to the top, last add bounces
    for (int i = 0; i < 14; i++) send_cmd(CMD_ADD, 32'd100 + i, i);

    // Random: phases that drain, fill and mix
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (n == HOLD_AT_ITEM) rx_hold_req = 1'b1;

      phase = (n / 150) % 3;
      r     = $urandom_range(0, 99);
      case (phase)
        0: op = (r < 20) ? CMD_ADD : (r < 35) ? CMD_MODIFY : (r < 80) ? CMD_REMOVE : CMD_TICK;
        1: op = (r < 55) ? CMD_ADD : (r < 70) ? CMD_MODIFY : (r < 85) ? CMD_REMOVE : CMD_TICK;
        default:
           op = (r < 35) ? CMD_ADD : (r < 55) ? CMD_MODIFY : (r < 75) ? CMD_REMOVE : CMD_TICK;
      endcase

      if (op == CMD_ADD) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: id = $urandom();
          6, 7, 8:          id = $urandom_range(0, 15);   // invites duplicates
          default:          id = $urandom_range(0, 1) ? '1 : '0;
        endcase
      end else if (id_pool.size() != 0 && $urandom_range(0, 9) < 8) begin
        id = id_pool[$urandom_range(0, id_pool.size() - 1)];
      end else begin
        id = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 15);
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3: ofs = $urandom_range(0, 40);
        4, 5, 6:    ofs = $urandom();
        7:          ofs = {TIME_W{1'b1}} - $urandom_range(0, 40);   // start wraps
        8:          ofs = $urandom_range(0, 3);                     // frequent ties
        default:    ofs = {TIME_W{1'b1}};
      endcase

      send_cmd(op, id, ofs);
    end
    cmd_if.valid <= 1'b0;

    // Let every outstanding result come back, then a little longer
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
